/* hdl/icadm_pkg.sv */
// Shared types and constants for the interval capacity admission block.
package icadm_pkg;

  localparam int unsigned NUM_POSITIONS_DEF = 1024;
  localparam int unsigned POS_W = 11;
  localparam int unsigned AMT_W = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POSITIONS = 1'b1;

  localparam logic [AMT_W-1:0] CAPACITY_RST = 16'd0;
  localparam logic [POS_W-1:0] POSITIONS_RST = 11'd1024;

  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_CLEAR  = 4'd1,
    OP_START  = 4'd2,
    OP_QTAG   = 4'd3,
    OP_QSEL   = 4'd4,
    OP_QFIN   = 4'd5,
    OP_DECIDE = 4'd6,
    OP_RDCL   = 4'd7,
    OP_RDCR   = 4'd8,
    OP_RDT    = 4'd9,
    OP_RDS    = 4'd10,
    OP_WPR    = 4'd11,
    OP_WSL    = 4'd12,
    OP_WSR    = 4'd13
  } icadm_op_e;

  typedef struct packed {
    icadm_op_e op;
    logic      load;
    logic      push;
  } icadm_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic empty;
    logic last_level;
    logic update;
  } icadm_status_t;

endpackage

/* hdl/icadm_dp.sv */
// Datapath: node memory, range pointers, running maxima and configuration registers.
module icadm_dp #(
  parameter int unsigned NUM_POSITIONS = icadm_pkg::NUM_POSITIONS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [icadm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [icadm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [icadm_pkg::POS_W-1:0]       first_position_i,
  input  logic [icadm_pkg::POS_W-1:0]       last_position_i,
  input  logic [icadm_pkg::AMT_W-1:0]       amount_i,
  output logic                              accepted_o,
  input  icadm_pkg::icadm_cmd_t             cmd_i,
  output icadm_pkg::icadm_status_t          status_o
);
  import icadm_pkg::*;

  localparam int unsigned LOG2P = $clog2(NUM_POSITIONS + 2);
  localparam int unsigned LEAF_BASE = 1 << LOG2P;
  localparam int unsigned DEPTH = 2 * LEAF_BASE;
  localparam int unsigned AW = LOG2P + 1;
  localparam int unsigned LVL_W = $clog2(LOG2P + 1);
  localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LOG2P);

  typedef struct packed {
    logic [AMT_W-1:0] mx;
    logic [AMT_W-1:0] tag;
  } node_t;

  function automatic logic [AMT_W-1:0] max16(input logic [AMT_W-1:0] a,
                                             input logic [AMT_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  node_t mem [DEPTH];
  node_t rd_a_q, rd_b_q, wd;
  logic [AW-1:0] ra, rb, wa;
  logic re, we;

  logic [AMT_W-1:0] cap_q;
  logic [POS_W-1:0] piu_q;
  logic [AW-1:0] clr_q;
  logic [LVL_W-1:0] lvl_q;

  logic [POS_W-1:0] first_q, last_q;
  logic [AMT_W-1:0] amt_q;
  logic [AW-1:0] pl_q, pr_q, pl0_q, pr0_q;
  logic empty_q;
  logic [AMT_W-1:0] resl_q, resr_q, maxl_q, maxr_q, tagr_q;
  logic vl_q, vr_q, sell_q, selr_q;
  logic adm_q, accepted_q;

  logic [POS_W-1:0] n_c, lo_c, hi_c;
  logic empty_c;
  logic [AW-1:0] pl0_c, pr0_c;
  logic active;
  logic [AMT_W-1:0] maxa_l, maxa_r, top_c;
  logic admit_c;

  // Clip the request to the row in use.
  assign n_c = (32'(piu_q) > NUM_POSITIONS) ? POS_W'(NUM_POSITIONS) : piu_q;
  assign lo_c = (first_q == '0) ? POS_W'(1) : first_q;
  assign hi_c = (last_q > n_c) ? n_c : last_q;
  assign empty_c = (n_c == '0) || (hi_c < lo_c);
  // Leaf of position p sits at LEAF_BASE + p; the pointers start just outside the range.
  assign pl0_c = AW'(LEAF_BASE + 32'(lo_c) - 32'd1);
  assign pr0_c = AW'(LEAF_BASE + 32'(hi_c) + 32'd1);

  assign active = (pl_q + AW'(1)) < pr_q;
  assign maxa_l = vl_q ? max16(resl_q, rd_a_q.mx) : rd_a_q.mx;
  assign maxa_r = vr_q ? max16(resr_q, rd_b_q.mx) : rd_b_q.mx;

  always_comb begin
    if (vl_q && vr_q) begin
      top_c = max16(resl_q, resr_q);
    end else if (vl_q) begin
      top_c = resl_q;
    end else if (vr_q) begin
      top_c = resr_q;
    end else begin
      top_c = '0;
    end
  end

  assign admit_c = ((AMT_W + 1)'(top_c) + (AMT_W + 1)'(amt_q)) <= (AMT_W + 1)'(cap_q);

  assign status_o.clr_done = (clr_q == AW'(DEPTH - 1));
  assign status_o.empty = empty_c;
  assign status_o.last_level = (lvl_q == LAST_LVL);
  assign status_o.update = admit_c && !empty_q;
  assign accepted_o = accepted_q;

  always_comb begin
    re = 1'b0;
    ra = pl_q;
    rb = pr_q;
    we = 1'b0;
    wa = pl_q;
    wd = '0;
    unique case (cmd_i.op)
      OP_CLEAR: begin
        we = 1'b1;
        wa = clr_q;
      end
      OP_QTAG, OP_RDT: begin
        re = 1'b1;
      end
      OP_QSEL: begin
        re = 1'b1;
        ra = pl_q + AW'(1);
        rb = pr_q - AW'(1);
      end
      OP_RDS: begin
        re = 1'b1;
        ra = pl_q + AW'(1);
        rb = pr_q - AW'(1);
        // Path node pl gets its maximum rebuilt from the children.
        we = (lvl_q != '0);
        wa = pl_q;
        wd.tag = rd_a_q.tag;
        wd.mx = maxl_q + rd_a_q.tag;
      end
      OP_RDCL: begin
        re = 1'b1;
        ra = {pl_q[AW-2:0], 1'b0};
        rb = {pl_q[AW-2:0], 1'b1};
      end
      OP_RDCR: begin
        re = 1'b1;
        ra = {pr_q[AW-2:0], 1'b0};
        rb = {pr_q[AW-2:0], 1'b1};
      end
      OP_WPR: begin
        we = (lvl_q != '0);
        wa = pr_q;
        wd.tag = tagr_q;
        wd.mx = maxr_q + tagr_q;
      end
      OP_WSL: begin
        we = sell_q;
        wa = pl_q + AW'(1);
        wd.mx = rd_a_q.mx + amt_q;
        wd.tag = rd_a_q.tag + amt_q;
      end
      OP_WSR: begin
        we = selr_q;
        wa = pr_q - AW'(1);
        wd.mx = rd_b_q.mx + amt_q;
        wd.tag = rd_b_q.tag + amt_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_a_q <= mem[ra];
      rd_b_q <= mem[rb];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAPACITY_RST;
      piu_q <= POSITIONS_RST;
      clr_q <= '0;
      lvl_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_CAPACITY:  cap_q <= cfg_wdata_i;
          CFG_POSITIONS: piu_q <= cfg_wdata_i[POS_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.op == OP_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.op == OP_START || cmd_i.op == OP_DECIDE) begin
        lvl_q <= '0;
      end else if (cmd_i.op == OP_QSEL || cmd_i.op == OP_WSR) begin
        lvl_q <= lvl_q + LVL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      first_q <= first_position_i;
      last_q <= last_position_i;
      amt_q <= amount_i;
    end
    if (cmd_i.push) begin
      accepted_q <= adm_q;
    end
    unique case (cmd_i.op)
      OP_START: begin
        pl_q <= pl0_c;
        pr_q <= pr0_c;
        pl0_q <= pl0_c;
        pr0_q <= pr0_c;
        empty_q <= empty_c;
        vl_q <= 1'b0;
        vr_q <= 1'b0;
        sell_q <= 1'b0;
        selr_q <= 1'b0;
      end
      OP_QTAG, OP_QFIN: begin
        // Fold in the span nodes picked one level below.
        if (sell_q) begin
          resl_q <= maxa_l;
          vl_q <= 1'b1;
        end
        if (selr_q) begin
          resr_q <= maxa_r;
          vr_q <= 1'b1;
        end
      end
      OP_QSEL: begin
        // Pending adds of the pointer nodes cover everything picked so far.
        if (lvl_q != '0) begin
          if (vl_q) begin
            resl_q <= resl_q + rd_a_q.tag;
          end
          if (vr_q) begin
            resr_q <= resr_q + rd_b_q.tag;
          end
        end
        sell_q <= active && !pl_q[0];
        selr_q <= active && pr_q[0];
        pl_q <= pl_q >> 1;
        pr_q <= pr_q >> 1;
      end
      OP_DECIDE: begin
        adm_q <= admit_c;
        pl_q <= pl0_q;
        pr_q <= pr0_q;
      end
      OP_RDCR: begin
        maxl_q <= max16(rd_a_q.mx, rd_b_q.mx);
      end
      OP_RDT: begin
        maxr_q <= max16(rd_a_q.mx, rd_b_q.mx);
      end
      OP_RDS: begin
        tagr_q <= rd_b_q.tag;
        sell_q <= active && !pl_q[0];
        selr_q <= active && pr_q[0];
      end
      OP_WSR: begin
        pl_q <= pl_q >> 1;
        pr_q <= pr_q >> 1;
      end
      default: begin
      end
    endcase
  end

  a_nonempty_has_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_DECIDE && !empty_q) |-> (vl_q || vr_q))
    else $error("nonempty range ended the query without a maximum");

  a_walk_ends_at_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_WSR && lvl_q == LAST_LVL) |-> (pl_q == AW'(1) && pr_q == AW'(1)))
    else $error("update walk did not end at the root");

  // Above the level where the two paths join, both pointers name the same node.
  a_pointer_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_QSEL) |-> (pl_q <= pr_q))
    else $error("range pointers crossed");

endmodule

/* hdl/icadm_ctrl.sv */
// Controller: sequences the clearing pass, the query walk and the update walk.
module icadm_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output icadm_pkg::icadm_cmd_t     cmd_o,
  input  icadm_pkg::icadm_status_t  status_i
);
  import icadm_pkg::*;

  typedef enum logic [14:0] {
    S_CLEAR  = 15'h0001,
    S_IDLE   = 15'h0002,
    S_START  = 15'h0004,
    S_QTAG   = 15'h0008,
    S_QSEL   = 15'h0010,
    S_QFIN   = 15'h0020,
    S_DECIDE = 15'h0040,
    S_RDCL   = 15'h0080,
    S_RDCR   = 15'h0100,
    S_RDT    = 15'h0200,
    S_RDS    = 15'h0400,
    S_WPR    = 15'h0800,
    S_WSL    = 15'h1000,
    S_WSR    = 15'h2000,
    S_DONE   = 15'h4000
  } state_e;

  state_e state_q, state_d;
  logic out_valid_q;
  logic slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_NONE;
    cmd_o.load = 1'b0;
    cmd_o.push = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (status_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_START;
        end
      end
      S_START: begin
        cmd_o.op = OP_START;
        state_d = status_i.empty ? S_DECIDE : S_QTAG;
      end
      S_QTAG: begin
        cmd_o.op = OP_QTAG;
        state_d = S_QSEL;
      end
      S_QSEL: begin
        cmd_o.op = OP_QSEL;
        state_d = status_i.last_level ? S_QFIN : S_QTAG;
      end
      S_QFIN: begin
        cmd_o.op = OP_QFIN;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.op = OP_DECIDE;
        // The leaf level has nothing to rebuild, so it starts at the span reads.
        state_d = status_i.update ? S_RDS : S_DONE;
      end
      S_RDCL: begin
        cmd_o.op = OP_RDCL;
        state_d = S_RDCR;
      end
      S_RDCR: begin
        cmd_o.op = OP_RDCR;
        state_d = S_RDT;
      end
      S_RDT: begin
        cmd_o.op = OP_RDT;
        state_d = S_RDS;
      end
      S_RDS: begin
        cmd_o.op = OP_RDS;
        state_d = S_WPR;
      end
      S_WPR: begin
        cmd_o.op = OP_WPR;
        state_d = S_WSL;
      end
      S_WSL: begin
        cmd_o.op = OP_WSL;
        state_d = S_WSR;
      end
      S_WSR: begin
        cmd_o.op = OP_WSR;
        state_d = status_i.last_level ? S_DONE : S_RDCL;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.push = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result beat raised outside the final state");

  a_update_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDCL || state_q == S_RDS) |-> !status_i.empty)
    else $error("update walk started for an empty range");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result beat dropped while stalled");

endmodule

/* hdl/interval_capacity_admission_top.sv */
// Top level of the interval capacity admission block.
//
//  channel   direction  handshake                  payload
//  in        sink       in_valid_i / in_stall_o    first_position_i, last_position_i, amount_i
//  out       source     out_valid_o / out_stall_i  accepted_o
//  cfg       sink       cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// One request at a time. An empty range skips the query walk, and only an admitted
// request over a nonempty range runs the update walk. With L = clog2(NUM_POSITIONS + 2)
// (11 by default), a clearing pass after reset zeroes all 2**(L+1) entries (4096) of the
// node memory; no request beat is taken meanwhile, configuration writes are.
// A finished result waits in the output register; the next request beat is taken while it waits.
module interval_capacity_admission_top #(
  parameter int unsigned NUM_POSITIONS = icadm_pkg::NUM_POSITIONS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [icadm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [icadm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [icadm_pkg::POS_W-1:0]       first_position_i,
  input  logic [icadm_pkg::POS_W-1:0]       last_position_i,
  input  logic [icadm_pkg::AMT_W-1:0]       amount_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              accepted_o
);
  import icadm_pkg::*;

  icadm_cmd_t    cmd;
  icadm_status_t status;

  icadm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  icadm_dp #(
    .NUM_POSITIONS (NUM_POSITIONS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .first_position_i (first_position_i),
    .last_position_i  (last_position_i),
    .amount_i         (amount_i),
    .accepted_o       (accepted_o),
    .cmd_i            (cmd),
    .status_o         (status)
  );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the interval capacity admission block.
`timescale 1ns / 100ps

module tb;
  import icadm_pkg::*;

  localparam int unsigned NPOS = 1024;

  typedef struct packed {
    logic [POS_W-1:0] first_pos;
    logic [POS_W-1:0] last_pos;
    logic [AMT_W-1:0] amt;
  } request_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_CAPACITY;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [POS_W-1:0]      first_position_i = '0;
  logic [POS_W-1:0]      last_position_i = '0;
  logic [AMT_W-1:0]      amount_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  accepted_o;

  interval_capacity_admission_top i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Flat occupancy per position; equivalent to the lazy tree.
  logic [AMT_W-1:0] occupancy [1:NPOS];
  int unsigned      cap_now;
  int unsigned      rows_now;
  request_t         pending_reqs [$];
  logic             admit_expected [$];
  int unsigned      error_count = 0;
  int unsigned      burst_left = 0;
  int unsigned      gap_left = 0;
  int unsigned      hold_cycles = 0;
  bit               hold_request = 1'b0;
  int unsigned      stall_mode = 0;
  bit               stim_done = 1'b0;

  function automatic logic predict_admission(request_t r);
    int unsigned lo, hi, n, top;
    bit empty;
    n = (rows_now > NPOS) ? NPOS : rows_now;
    lo = (r.first_pos < 1) ? 1 : 32'(r.first_pos);
    hi = (r.last_pos > n) ? n : 32'(r.last_pos);
    empty = (n == 0) || (hi < lo);
    top = 0;
    if (!empty)
      for (int unsigned p = lo; p <= hi; p++)
        if (occupancy[p] > top) top = 32'(occupancy[p]);
    if (top + r.amt <= cap_now) begin
      if (!empty)
        for (int unsigned p = lo; p <= hi; p++) occupancy[p] += r.amt;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Driver: bursts and gaps; the payload holds while stalled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        admit_expected.push_back(predict_admission(pending_reqs.pop_front()));
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_valid_i <= 1'b1;
          first_position_i <= pending_reqs[0].first_pos;
          last_position_i <= pending_reqs[0].last_pos;
          amount_i <= pending_reqs[0].amt;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 8);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 30);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_request && hold_cycles == 0) hold_cycles = 2000;
    if (hold_cycles > 0) begin
      hold_cycles--;
      if (hold_cycles == 0) hold_request = 1'b0;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ($urandom_range(0, 99) < 70);
      endcase
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (admit_expected.size() == 0) begin
        report_mismatch("result beat with no request outstanding");
      end else if (accepted_o !== admit_expected[0]) begin
        report_mismatch($sformatf("accepted %b, expected %b", accepted_o, admit_expected[0]));
        void'(admit_expected.pop_front());
      end else begin
        void'(admit_expected.pop_front());
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_CAPACITY) cap_now = val & 16'hFFFF;
    else rows_now = val & 11'h7FF;
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && !in_valid_i && admit_expected.size() == 0);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic request_t make_req(int unsigned f, int unsigned l, int unsigned a);
    request_t r;
    r.first_pos = POS_W'(f);
    r.last_pos = POS_W'(l);
    r.amt = AMT_W'(a);
    return r;
  endfunction

  // Mostly small amounts so that occupancy builds up toward capacity.
  function automatic request_t random_req(int unsigned span_max);
    int unsigned f, len;
    f = $urandom_range(0, 1024);
    len = $urandom_range(0, span_max);
    if ($urandom_range(0, 9) == 0)
      return make_req($urandom_range(0, 2047), $urandom_range(0, 2047), $urandom);
    return make_req(f, (f + len > 1024) ? 1024 : f + len,
                    ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, cap_now / 8 + 1));
  endfunction

  initial begin
    for (int p = 1; p <= NPOS; p++) occupancy[p] = '0;
    cap_now = 32'(CAPACITY_RST);
    rows_now = 32'(POSITIONS_RST);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Capacity zero after reset: only zero amounts pass, over any range.
    pending_reqs.push_back(make_req(1, 1024, 0));
    pending_reqs.push_back(make_req(5, 5, 1));
    pending_reqs.push_back(make_req(7, 3, 0));
    drain();

    write_reg(CFG_CAPACITY, 65535);
    pending_reqs.push_back(make_req(1, 1024, 65535));
    pending_reqs.push_back(make_req(1, 1, 1));
    pending_reqs.push_back(make_req(9, 2, 1));
    pending_reqs.push_back(make_req(2, 1, 65535));
    drain();
    write_reg(CFG_CAPACITY, 65535);
    for (int p = 1; p <= NPOS; p++) occupancy[p] = occupancy[p];
    drain();

    // Fresh headroom is gone; try small, zero and oversized rows at the same capacity.
    write_reg(CFG_POSITIONS, 1);
    pending_reqs.push_back(make_req(0, 2047, 0));
    pending_reqs.push_back(make_req(1, 1, 1));
    drain();
    write_reg(CFG_POSITIONS, 0);
    pending_reqs.push_back(make_req(1, 1024, 100));
    pending_reqs.push_back(make_req(1024, 1024, 65535));
    drain();
    write_reg(CFG_POSITIONS, 2047);
    pending_reqs.push_back(make_req(1024, 1024, 0));
    pending_reqs.push_back(make_req(1024, 2047, 0));
    drain();
    write_reg(CFG_POSITIONS, 1024);
    // Occupancy is saturated; further random work checks rejects mostly.
    for (int i = 0; i < 60; i++) pending_reqs.push_back(random_req(1024));
    hold_request = 1'b1;
    drain();

    // Regions beyond the full row are still saturated; the tree cannot be reset,
    // so even phases use capacity 65535 (zero amounts pass, rest fail on touched
    // ranges) and odd phases a random one. Reduce rows to explore clipping.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_CAPACITY, (ph % 2) ? $urandom_range(0, 65535) : 65535);
      write_reg(CFG_POSITIONS, (ph == 5) ? 1024 : $urandom_range(1, 1100));
      for (int i = 0; i < 90; i++) pending_reqs.push_back(random_req(ph < 3 ? 16 : 1024));
      if (ph == 2) hold_request = 1'b1;
      drain();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (error_count == 0) begin
      $display("PASS interval_capacity_admission_top");
    end else begin
      $display("FAIL interval_capacity_admission_top");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL interval_capacity_admission_top");
    $finish;
  end

endmodule

/* filelist.f */
hdl/icadm_pkg.sv
hdl/icadm_dp.sv
hdl/icadm_ctrl.sv
hdl/interval_capacity_admission_top.sv
tb/tb.sv
